@@ src/farbfeld_to_argb_decoder_top_defines.svh @@
// assertion macros shared by the farbfeld decoder modules
// expects clk and rst_n in scope where a macro is used
`ifndef FARBFELD_TO_ARGB_DECODER_TOP_DEFINES_SVH
`define FARBFELD_TO_ARGB_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fta_pkg.sv @@
// types, constants and helpers for the farbfeld to argb decoder
// no dependencies; used by every module of the block
package fta_pkg;

    // bar height register
    localparam int BAR_W = 12;
    localparam logic [BAR_W-1:0] BAR_RESET  = 12'd24;
    localparam logic [BAR_W-1:0] BAR_MARGIN = 12'd2;

    // header layout: magic, then width, then height
    localparam int HCNT_W = 5;
    localparam logic [HCNT_W-1:0] MAGIC_LEN   = 5'd8;
    localparam logic [HCNT_W-1:0] WIDTH_END   = 5'd12;
    localparam logic [HCNT_W-1:0] HEADER_LAST = 5'd15;
    localparam logic [HCNT_W-1:0] HEADER_LEN  = 5'd16;

    // byte positions inside one rgba16 pixel (high bytes only)
    localparam logic [2:0] POS_RED   = 3'd0;
    localparam logic [2:0] POS_GREEN = 3'd2;
    localparam logic [2:0] POS_BLUE  = 3'd4;
    localparam logic [2:0] POS_ALPHA = 3'd6;
    localparam logic [2:0] POS_LAST  = 3'd7;

    // fitted width divider: dividend is width times fitted height
    localparam int DIM_W     = 32;
    localparam int DIV_BITS  = DIM_W + BAR_W;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_BITS - 1);

    // result kinds and error codes
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic ERR_HEADER = 1'b0;
    localparam logic ERR_PIXELS = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_MUL,
        ST_DIV,
        ST_HDR,
        ST_ERR
    } ctl_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      argb;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [DIM_W-1:0] shown_width;
        logic [DIM_W-1:0] shown_height;
        logic             error_code;
        logic             last_of_run;
    } res_item_t;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic mul;
        logic div;
        logic hdr_load;
        logic err_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hdr_ok_end;
        logic emit_now;
        logic err_follow;
        logic eof_hold;
        logic pix_owed;
    } dp_sts_t;

    // the eight magic bytes "farbfeld"
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0: val = 8'h66;
            3'd1: val = 8'h61;
            3'd2: val = 8'h72;
            3'd3: val = 8'h62;
            3'd4: val = 8'h66;
            3'd5: val = 8'h65;
            3'd6: val = 8'h6C;
            3'd7: val = 8'h64;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

@@ src/farbfeld_to_argb_decoder_top.sv @@
// farbfeld decoder: one file byte per item; a data byte's result item is valid
// the cycle after it is accepted, so bytes flow at one per cycle while results
// drain and no header or error item is pending; the last header byte stalls input
// through the multiply, the bit-serial width divider and the header item load
// eof just after a whole pixel with pixels still owed stalls input for an error item
// reset (rst_n, async, active low) returns to the header phase with bar height 24
module farbfeld_to_argb_decoder_top
    import fta_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_ready,
    input  byte_item_t       byte_item,
    output logic             res_valid,
    input  logic             res_ready,
    output res_item_t        res_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [BAR_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // the bar height register takes a write on any cycle
    assign cfg_ready = 1'b1;

    // sequencing and handshakes
    fta_controller u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // stream state, arithmetic and result register
    fta_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_bar   (cfg_data),
        .byte_item (byte_item),
        .cmd       (cmd),
        .sts       (sts),
        .res_item  (res_item)
    );

endmodule

@@ src/fta_datapath.sv @@
// datapath of the farbfeld decoder: header and pixel state, multipliers,
// bit-serial divider and the result register; depends on fta_pkg and the defines header
`include "farbfeld_to_argb_decoder_top_defines.svh"

module fta_datapath
    import fta_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [BAR_W-1:0] cfg_bar,
    input  byte_item_t       byte_item,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    output res_item_t        res_item
);

    // stream state
    phase_t                phase_reg, phase_next;
    logic [HCNT_W-1:0]     hcount_reg, hcount_next;
    logic                  magic_ok_reg, magic_ok_next;
    logic [DIM_W-1:0]      width_reg, width_next;
    logic [DIM_W-1:0]      height_reg, height_next;
    logic [2*DIM_W-1:0]    pixels_left_reg, pixels_left_next;
    logic [2:0]            bip_reg, bip_next;
    logic [23:0]           pix_acc_reg, pix_acc_next;
    logic [7:0]            alpha_reg, alpha_next;
    logic [BAR_W-1:0]      bar_reg, bar_next;
    logic                  eof_hold_reg, eof_hold_next;

    // arithmetic and result payload
    logic [2*DIM_W-1:0]    prod_reg, prod_next;
    logic [DIV_BITS-1:0]   num_reg, num_next;
    logic [DIM_W-1:0]      rem_reg, rem_next;
    res_item_t             res_reg, res_next;

    // step values for the byte on the input
    phase_t                stp_phase;
    logic [HCNT_W-1:0]     stp_hcount;
    logic                  stp_magic;
    logic [DIM_W-1:0]      stp_width;
    logic [DIM_W-1:0]      stp_height;
    logic [2*DIM_W-1:0]    stp_left;
    logic [2:0]            stp_bip;
    logic [23:0]           stp_pix;
    logic [7:0]            stp_alpha;
    res_item_t             stp_res;
    logic                  emit;
    logic                  follow;
    logic                  ok_end;

    logic [7:0]            b;
    logic                  eof;
    logic [BAR_W-1:0]      fit;
    logic                  fit_apply;
    logic [DIM_W:0]        shifted;
    logic [DIM_W:0]        diff;
    logic                  ge;
    logic                  do_clear;
    res_item_t             hdr_res;
    res_item_t             err_res;

    assign b   = byte_item.data_byte;
    assign eof = byte_item.end_of_file;

    // fitted height, saturated at zero
    assign fit = (bar_reg > BAR_MARGIN) ? (bar_reg - BAR_MARGIN) : '0;
    assign fit_apply = (height_reg != '0) && (height_reg >= DIM_W'(bar_reg));

    // effect of one byte on the stream state
    always_comb
    begin
        stp_phase  = phase_reg;
        stp_hcount = hcount_reg;
        stp_magic  = magic_ok_reg;
        stp_width  = width_reg;
        stp_height = height_reg;
        stp_left   = pixels_left_reg;
        stp_bip    = bip_reg;
        stp_pix    = pix_acc_reg;
        stp_alpha  = alpha_reg;
        stp_res    = '0;
        emit       = 1'b0;
        follow     = 1'b0;
        ok_end     = 1'b0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (hcount_reg < MAGIC_LEN)
                begin
                    if (b != magic_byte(hcount_reg[2:0]))
                        stp_magic = 1'b0;
                end
                else if (hcount_reg < WIDTH_END)
                    stp_width = {width_reg[DIM_W-9:0], b};
                else
                    stp_height = {height_reg[DIM_W-9:0], b};
                stp_hcount = hcount_reg + 1'b1;
                if (hcount_reg == HEADER_LAST)
                begin
                    if (!stp_magic)
                    begin
                        emit               = 1'b1;
                        stp_res.kind       = KIND_ERROR;
                        stp_res.error_code = ERR_HEADER;
                        stp_phase          = PH_DONE;
                    end
                    else
                        ok_end = 1'b1;
                end
                else if (eof)
                begin
                    emit               = 1'b1;
                    stp_res.kind       = KIND_ERROR;
                    stp_res.error_code = ERR_HEADER;
                end
            end
            PH_PIXELS:
            begin
                case (bip_reg)
                    POS_RED:   stp_pix[23:16] = b;
                    POS_GREEN: stp_pix[15:8]  = b;
                    POS_BLUE:  stp_pix[7:0]   = b;
                    POS_ALPHA: stp_alpha      = b;
                    default:   stp_alpha      = alpha_reg;
                endcase
                if (bip_reg == POS_LAST)
                begin
                    emit         = 1'b1;
                    stp_res.kind = KIND_PIXEL;
                    stp_res.argb = {alpha_reg, pix_acc_reg};
                    stp_bip      = '0;
                    stp_left     = pixels_left_reg - 1'b1;
                    if (stp_left == '0)
                        stp_phase = PH_DONE;
                end
                else
                    stp_bip = bip_reg + 1'b1;
                // file ends while pixels are still owed
                if (eof && (stp_phase == PH_PIXELS))
                begin
                    if (emit)
                        follow = 1'b1;
                    else
                    begin
                        emit               = 1'b1;
                        stp_res.kind       = KIND_ERROR;
                        stp_res.error_code = ERR_PIXELS;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        stp_res.last_of_run = !follow;
    end

    // header and trailing error results
    always_comb
    begin
        hdr_res              = '0;
        hdr_res.kind         = KIND_HEADER;
        hdr_res.image_width  = width_reg;
        hdr_res.image_height = height_reg;
        hdr_res.shown_width  = fit_apply ? num_reg[DIM_W-1:0] : width_reg;
        hdr_res.shown_height = fit_apply ? DIM_W'(fit) : height_reg;
        hdr_res.last_of_run  = !(eof_hold_reg && (prod_reg != '0));
        err_res              = '0;
        err_res.kind         = KIND_ERROR;
        err_res.error_code   = ERR_PIXELS;
        err_res.last_of_run  = 1'b1;
    end

    // stream state next values
    always_comb
    begin
        phase_next       = phase_reg;
        hcount_next      = hcount_reg;
        magic_ok_next    = magic_ok_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        pixels_left_next = pixels_left_reg;
        bip_next         = bip_reg;
        pix_acc_next     = pix_acc_reg;
        alpha_next       = alpha_reg;
        eof_hold_next    = eof_hold_reg;
        do_clear         = 1'b0;
        if (cmd.step)
        begin
            phase_next       = stp_phase;
            hcount_next      = stp_hcount;
            magic_ok_next    = stp_magic;
            width_next       = stp_width;
            height_next      = stp_height;
            pixels_left_next = stp_left;
            bip_next         = stp_bip;
            pix_acc_next     = stp_pix;
            alpha_next       = stp_alpha;
            eof_hold_next    = eof;
            // a finished header keeps its size until the header item is out
            do_clear         = eof && !ok_end;
        end
        if (cmd.hdr_load)
        begin
            pixels_left_next = prod_reg;
            bip_next         = '0;
            phase_next       = (prod_reg != '0) ? PH_PIXELS : PH_DONE;
            do_clear         = eof_hold_reg;
        end
        if (do_clear)
        begin
            phase_next       = PH_HEADER;
            hcount_next      = '0;
            magic_ok_next    = 1'b1;
            width_next       = '0;
            height_next      = '0;
            pixels_left_next = '0;
            bip_next         = '0;
            pix_acc_next     = '0;
            alpha_next       = '0;
        end
        bar_next = cfg_we ? cfg_bar : bar_reg;
    end

    // one restoring divide step per cycle
    assign shifted = {rem_reg, num_reg[DIV_BITS-1]};
    assign ge      = shifted >= {1'b0, height_reg};
    assign diff    = shifted - {1'b0, height_reg};

    // multipliers, divider and result register
    always_comb
    begin
        prod_next = prod_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        if (cmd.mul)
        begin
            prod_next = {{DIM_W{1'b0}}, width_reg} * {{DIM_W{1'b0}}, height_reg};
            num_next  = {{BAR_W{1'b0}}, width_reg} * {{DIM_W{1'b0}}, fit};
            rem_next  = '0;
        end
        else if (cmd.div)
        begin
            num_next = {num_reg[DIV_BITS-2:0], ge};
            rem_next = ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
        end
        if (cmd.step && emit)
            res_next = stp_res;
        else if (cmd.hdr_load)
            res_next = hdr_res;
        else if (cmd.err_load)
            res_next = err_res;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            hcount_reg      <= '0;
            magic_ok_reg    <= 1'b1;
            width_reg       <= '0;
            height_reg      <= '0;
            pixels_left_reg <= '0;
            bip_reg         <= '0;
            pix_acc_reg     <= '0;
            alpha_reg       <= '0;
            bar_reg         <= BAR_RESET;
            eof_hold_reg    <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            hcount_reg      <= hcount_next;
            magic_ok_reg    <= magic_ok_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            pixels_left_reg <= pixels_left_next;
            bip_reg         <= bip_next;
            pix_acc_reg     <= pix_acc_next;
            alpha_reg       <= alpha_next;
            bar_reg         <= bar_next;
            eof_hold_reg    <= eof_hold_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    // status to the controller
    always_comb
    begin
        sts.hdr_ok_end = ok_end;
        sts.emit_now   = emit;
        sts.err_follow = follow;
        sts.eof_hold   = eof_hold_reg;
        sts.pix_owed   = prod_reg != '0;
    end

    assign res_item = res_reg;

    `FTA_ASSERT_NOW(a_pix_owed, phase_reg == PH_PIXELS, pixels_left_reg != '0, "pixel phase with no pixels left")
    `FTA_ASSERT_NOW(a_hdr_count, phase_reg == PH_HEADER, (hcount_reg <= HEADER_LEN) && (bip_reg == '0), "header phase counters out of range")
    `FTA_ASSERT_NEXT(a_hdr_leaves, cmd.hdr_load && !eof_hold_reg, phase_reg != PH_HEADER, "header result did not end the header phase")

endmodule

@@ src/fta_controller.sv @@
// controller of the farbfeld decoder: sequences byte steps, the header
// multiply and divide, and the result handshake; depends on fta_pkg and the defines header
`include "farbfeld_to_argb_decoder_top_defines.svh"

module fta_controller
    import fta_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    byte_valid,
    output logic    byte_ready,
    output logic    res_valid,
    input  logic    res_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctl_state_t           st_reg, st_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 out_free;
    logic                 accept;
    logic [2:0]           load_vec;
    logic                 any_load;

    // result register may take a new item when empty or being drained
    assign out_free = !res_valid_reg || res_ready;
    assign accept   = byte_valid && byte_ready;

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (sts.hdr_ok_end)
                        st_next = ST_MUL;
                    else if (sts.err_follow)
                        st_next = ST_ERR;
                end
            end
            ST_MUL:
                st_next = ST_DIV;
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    st_next = ST_HDR;
            end
            ST_HDR:
            begin
                if (out_free)
                    st_next = (sts.eof_hold && sts.pix_owed) ? ST_ERR : ST_RUN;
            end
            ST_ERR:
            begin
                if (out_free)
                    st_next = ST_RUN;
            end
            default:
                st_next = ST_RUN;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        byte_ready   = 1'b0;
        cmd          = '0;
        div_cnt_next = div_cnt_reg;
        unique case (st_reg)
            ST_RUN:
            begin
                byte_ready = out_free;
                cmd.step   = byte_valid && out_free;
            end
            ST_MUL:
            begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
            end
            ST_DIV:
            begin
                cmd.div      = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_HDR:
                cmd.hdr_load = out_free;
            ST_ERR:
                cmd.err_load = out_free;
            default:
                byte_ready = 1'b0;
        endcase
    end

    // result valid tracking
    assign load_vec = {cmd.step && sts.emit_now, cmd.hdr_load, cmd.err_load};
    assign any_load = load_vec != '0;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (any_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_RUN;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            div_cnt_reg   <= div_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    `FTA_ASSERT_NEXT(a_div_done, (st_reg == ST_DIV) && (div_cnt_reg == DIV_LAST), st_reg == ST_HDR, "divider did not hand over to header output")
    `FTA_ASSERT_NOW(a_one_load, 1'b1, $onehot0(load_vec), "two result loads in one cycle")
    `FTA_ASSERT_NOW(a_load_free, any_load, !res_valid_reg || res_ready, "result register overwritten while held")

endmodule
